FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers shared by the string dedup rtl, empty when SYNTH is set
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// property must hold at every clock edge out of reset
`define ASSERT_AT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// expression must never be true out of reset
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);

`else

`define ASSERT_AT(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg)

`endif

`endif

FILE: src/asd_pkg.sv
// ----------------------------------------------------------------------------
// asd_pkg
// shared constants and controller/datapath interface types
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package asd_pkg;

	localparam int MAX_LEN_DEF = 64;
	localparam int CNT_W       = 32;
	localparam int BYTE_W      = 8;

	// commands from controller to datapath
	typedef struct packed {
		logic take;    // accept one data byte
		logic cmp;     // fold compare result into mismatch flag
		logic finish;  // string done, decide keep or drop
		logic rd;      // read one byte of the kept string
		logic next;    // result item taken, advance replay index
	} asd_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic full;       // current string already at max length
		logic differ;     // current string differs from kept one
		logic len_zero;   // current string is empty
		logic emit_last;  // replay is on its final item
	} asd_sts_t;

endpackage

`default_nettype wire

FILE: src/asd_datapath.sv
// ----------------------------------------------------------------------------
// asd_datapath
// string buffers, compare, running totals and replay of kept strings
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module asd_datapath
	import asd_pkg::*;
#(
	parameter int MAX_LEN = MAX_LEN_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire asd_cmd_t          cmd,
	output asd_sts_t               sts,
	input  wire logic [BYTE_W-1:0] in_byte,
	output logic [BYTE_W-1:0]      out_byte,
	output logic                   out_empty,
	output logic                   out_last,
	output logic [CNT_W-1:0]       end_offset,
	output logic [CNT_W-1:0]       kept_count,
	output logic                   too_long
);

	localparam int LEN_W  = $clog2(MAX_LEN + 1);
	localparam int ADDR_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int DEPTH  = 2 ** (ADDR_W + 1);

	// two banks, one holds the kept string, the other collects the new one
	logic [BYTE_W-1:0] mem [DEPTH];

	logic              prev_bank_q;
	logic [LEN_W-1:0]  cur_len_q;
	logic [LEN_W-1:0]  prev_len_q;
	logic              mismatch_q;
	logic              overflow_q;
	logic [CNT_W-1:0]  total_q;
	logic [CNT_W-1:0]  bcount_q;
	logic [BYTE_W-1:0] byte_s1;
	logic              past_end_s1;
	logic [BYTE_W-1:0] rd_q;
	logic [LEN_W-1:0]  k_q;
	logic [LEN_W-1:0]  emit_len_q;
	logic              emit_empty_q;
	logic              tl_q;

	logic [ADDR_W:0]   wr_addr;
	logic [ADDR_W:0]   rd_addr;
	logic [CNT_W:0]    sum;

	assign sts.full      = (cur_len_q >= LEN_W'(MAX_LEN));
	assign sts.differ    = mismatch_q || (cur_len_q != prev_len_q);
	assign sts.len_zero  = (cur_len_q == '0);
	assign sts.emit_last = emit_empty_q || (k_q == emit_len_q - LEN_W'(1));

	assign wr_addr = {~prev_bank_q, cur_len_q[ADDR_W-1:0]};
	assign rd_addr = cmd.rd ? {prev_bank_q, k_q[ADDR_W-1:0]}
	                        : {prev_bank_q, cur_len_q[ADDR_W-1:0]};
	assign sum     = {1'b0, total_q} + (CNT_W + 1)'(cur_len_q);

	always_ff @(posedge clk) begin
		if (cmd.take && !sts.full) begin
			mem[wr_addr] <= in_byte;
		end
		if (cmd.take || cmd.rd) begin
			rd_q <= mem[rd_addr];
		end
		if (cmd.take) begin
			byte_s1     <= in_byte;
			past_end_s1 <= (cur_len_q >= prev_len_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_bank_q  <= 1'b0;
			cur_len_q    <= '0;
			prev_len_q   <= '0;
			mismatch_q   <= 1'b0;
			overflow_q   <= 1'b0;
			total_q      <= '0;
			bcount_q     <= CNT_W'(1);
			k_q          <= '0;
			emit_len_q   <= '0;
			emit_empty_q <= 1'b0;
			tl_q         <= 1'b0;
		end else begin
			if (cmd.take) begin
				if (sts.full) begin
					overflow_q <= 1'b1;
				end else begin
					cur_len_q <= cur_len_q + LEN_W'(1);
				end
			end
			if (cmd.cmp && (past_end_s1 || (rd_q != byte_s1))) begin
				mismatch_q <= 1'b1;
			end
			if (cmd.finish) begin
				if (sts.differ) begin
					total_q      <= sum[CNT_W] ? '1 : sum[CNT_W-1:0];
					if (bcount_q != '1) begin
						bcount_q <= bcount_q + CNT_W'(1);
					end
					prev_len_q   <= cur_len_q;
					prev_bank_q  <= ~prev_bank_q;
					emit_len_q   <= cur_len_q;
					emit_empty_q <= sts.len_zero;
					tl_q         <= overflow_q;
					k_q          <= '0;
				end
				cur_len_q  <= '0;
				mismatch_q <= 1'b0;
				overflow_q <= 1'b0;
			end
			if (cmd.next) begin
				k_q <= k_q + LEN_W'(1);
			end
		end
	end

	assign out_byte   = emit_empty_q ? '0 : rd_q;
	assign out_empty  = emit_empty_q;
	assign out_last   = sts.emit_last;
	assign end_offset = sts.emit_last ? total_q : '0;
	assign kept_count = sts.emit_last ? bcount_q : '0;
	assign too_long   = tl_q;

	`ASSERT_NEVER(a_len_bound, clk, arst_n, (cur_len_q > LEN_W'(MAX_LEN)) || (prev_len_q > LEN_W'(MAX_LEN)), "string length above max")
	`ASSERT_AT(a_finish_clears, clk, arst_n, cmd.finish |=> (cur_len_q == '0 && !mismatch_q && !overflow_q), "finish left string state")
	`ASSERT_NEVER(a_bcount_zero, clk, arst_n, bcount_q == '0, "boundary count wrapped to zero")

endmodule

`default_nettype wire

FILE: src/asd_ctrl.sv
// ----------------------------------------------------------------------------
// asd_ctrl
// sequencer for byte intake, compare, keep decision and replay
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module asd_ctrl
	import asd_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	input  wire logic     in_empty,
	input  wire logic     in_last,
	output logic          in_ready,
	output logic          out_valid,
	input  wire logic     out_ready,
	output asd_cmd_t      cmd,
	input  wire asd_sts_t sts
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CMP,
		ST_FIN,
		ST_RD,
		ST_OUT
	} state_t;

	state_t state_q;
	logic   last_q;
	logic   acc;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign acc       = in_valid && in_ready;

	assign cmd.take   = acc && !in_empty;
	assign cmd.cmp    = (state_q == ST_CMP);
	assign cmd.finish = (state_q == ST_FIN);
	assign cmd.rd     = (state_q == ST_RD);
	assign cmd.next   = out_valid && out_ready && !sts.emit_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			last_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (acc) begin
						last_q <= in_last;
						if (in_empty) begin
							state_q <= ST_FIN;
						end else if (sts.full) begin
							state_q <= in_last ? ST_FIN : ST_IDLE;
						end else begin
							state_q <= ST_CMP;
						end
					end
				end
				ST_CMP: begin
					state_q <= last_q ? ST_FIN : ST_IDLE;
				end
				ST_FIN: begin
					if (!sts.differ) begin
						state_q <= ST_IDLE;
					end else if (sts.len_zero) begin
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_RD;
					end
				end
				ST_RD: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_ready) begin
						state_q <= sts.emit_last ? ST_IDLE : ST_RD;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`ASSERT_AT(a_last_to_idle, clk, arst_n, (out_valid && out_ready && sts.emit_last) |=> in_ready, "no return to intake after last item")
	`ASSERT_NEVER(a_cmd_excl, clk, arst_n, !$onehot0({cmd.take, cmd.cmp, cmd.finish, cmd.rd, cmd.next}), "overlapping datapath commands")
	`ASSERT_AT(a_rd_then_out, clk, arst_n, cmd.rd |=> out_valid, "read not followed by result")

endmodule

`default_nettype wire

FILE: src/adjacent_string_dedup_top.sv
// ----------------------------------------------------------------------------
// adjacent_string_dedup_top
// drops a string that equals the previously kept one, replays kept strings
// ----------------------------------------------------------------------------
// data byte: intake, then compare against the kept string through the buffer's
//   registered read port; a byte past max length gets intake only
// end of string: keep decision, then per result item a buffer read, then show,
//   plus any output stall; a kept empty string gives 1 item
// throughput: one item at a time, bound by the single buffer read port
// reset: arst_n clears all control, lengths and totals; buffers are not cleared
`timescale 1ns / 1ps
`default_nettype none

module adjacent_string_dedup_top
	import asd_pkg::*;
#(
	parameter int MAX_LEN = MAX_LEN_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
	input  wire logic        s_tuser,   // [0] empty_string
	input  wire logic        s_tlast,   // last_byte
	// output stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [71:0]      m_tdata,   // [7:0] out_byte, [39:8] end_offset,
	                                    // [71:40] kept_count
	output logic [1:0]       m_tuser,   // [0] out_empty, [1] too_long
	output logic             m_tlast    // out_last
);

	asd_cmd_t          cmd;
	asd_sts_t          sts;
	logic [BYTE_W-1:0] out_byte;
	logic              out_empty;
	logic              out_last;
	logic [CNT_W-1:0]  end_offset;
	logic [CNT_W-1:0]  kept_count;
	logic              too_long;

	// sequencer: one item in flight, intake or replay
	asd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_empty  (s_tuser),
		.in_last   (s_tlast),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.cmd       (cmd),
		.sts       (sts)
	);

	// buffers, compare and running totals
	asd_datapath #(
		.MAX_LEN (MAX_LEN)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.in_byte    (s_tdata),
		.out_byte   (out_byte),
		.out_empty  (out_empty),
		.out_last   (out_last),
		.end_offset (end_offset),
		.kept_count (kept_count),
		.too_long   (too_long)
	);

	// pack result fields, lowest field first
	assign m_tdata = {kept_count, end_offset, out_byte};
	assign m_tuser = {too_long, out_empty};
	assign m_tlast = out_last;

endmodule

`default_nettype wire

FILE: bench/adjacent_string_dedup_top_tb.sv
// ----------------------------------------------------------------------------
// adjacent_string_dedup_top_tb
// streams strings into the dedup block and checks every replayed item against
// a behavioral prediction of which strings are kept and what each item carries
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module adjacent_string_dedup_top_tb
	import asd_pkg::*;
();

	localparam int CLK_HALF     = 2;
	localparam int RESET_CYCLES = 12;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_PAD    = 32;
	localparam int HOLD_CYCLES  = 400;
	localparam int PHASE_ITEMS  = 20;

	typedef logic [7:0] text_t [$];

	// one replayed item of a kept string
	typedef struct packed {
		logic [7:0]  data_val;
		logic        empty;
		logic        last;
		logic [31:0] end_off;
		logic [31:0] count;
		logic        too_long;
	} kept_item_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	wire         s_tready;
	logic [7:0]  s_tdata  = 8'h00;  // [7:0] data_byte
	logic        s_tuser  = 1'b0;   // [0] empty_string
	logic        s_tlast  = 1'b0;   // last_byte
	wire         m_tvalid;
	logic        m_tready = 1'b0;
	wire  [71:0] m_tdata;           // [7:0] out_byte, [39:8] end_offset, [71:40] kept_count
	wire  [1:0]  m_tuser;           // [0] out_empty, [1] too_long
	wire         m_tlast;           // out_last

	// predicted block state
	logic [7:0]  prev_bytes [MAX_LEN_DEF];
	logic [7:0]  cur_bytes  [MAX_LEN_DEF];
	int          prev_len    = 0;
	int          cur_len     = 0;
	logic        diff_seen   = 1'b0;
	logic        trunc_seen  = 1'b0;
	logic [31:0] kept_total  = 32'd0;
	logic [31:0] entry_count = 32'd1;
	kept_item_t  kept_replay_q [$];

	int    error_count    = 0;
	int    items_sent     = 0;
	int    send_idle_pct  = 0;
	int    recv_stall_pct = 0;
	int    hold_left      = 0;
	text_t recent_text;

	adjacent_string_dedup_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial begin
		forever #CLK_HALF clk = ~clk;
	end

	// string done: keep and replay it if it differs from the kept one
	function automatic void dedup_close_string();
		logic [32:0] sum;
		kept_item_t  r;
		int          k;
		if (diff_seen || cur_len != prev_len) begin
			sum = {1'b0, kept_total} + 33'(cur_len);
			kept_total = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
			if (entry_count != 32'hFFFF_FFFF)
				entry_count++;
			if (cur_len == 0) begin
				r = '{data_val: 8'h00, empty: 1'b1, last: 1'b1, end_off: kept_total,
					count: entry_count, too_long: trunc_seen};
				kept_replay_q.push_back(r);
			end
			for (k = 0; k < cur_len; k++) begin
				r.data_val = cur_bytes[k];
				r.empty    = 1'b0;
				r.last     = (k == cur_len - 1);
				r.end_off  = r.last ? kept_total : 32'd0;
				r.count    = r.last ? entry_count : 32'd0;
				r.too_long = trunc_seen;
				kept_replay_q.push_back(r);
			end
			prev_bytes = cur_bytes;
			prev_len   = cur_len;
		end
		cur_len    = 0;
		diff_seen  = 1'b0;
		trunc_seen = 1'b0;
	endfunction

	// one accepted input item
	function automatic void dedup_take_item(input logic [7:0] d, input logic e, input logic l);
		if (e) begin
			dedup_close_string();
		end else begin
			if (cur_len >= MAX_LEN_DEF) begin
				trunc_seen = 1'b1;
			end else begin
				if (cur_len >= prev_len || prev_bytes[cur_len] != d)
					diff_seen = 1'b1;
				cur_bytes[cur_len] = d;
				cur_len++;
			end
			if (l)
				dedup_close_string();
		end
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			error_count++;
			$display("%0t ns: %s expected %0h got %0h", $time, name, want, got);
		end
	endfunction

	// every accepted result is matched against the oldest prediction
	always @(posedge clk) begin : result_check
		kept_item_t want;
		kept_item_t got;
		if (m_tvalid && m_tready) begin
			got = {m_tdata[7:0], m_tuser[0], m_tlast, m_tdata[39:8], m_tdata[71:40], m_tuser[1]};
			if (kept_replay_q.size() == 0) begin
				error_count++;
				$display("%0t ns: unexpected item, expected none got %0h", $time, got);
			end else begin
				want = kept_replay_q.pop_front();
				check_field("out_byte", 32'(want.data_val), 32'(got.data_val));
				check_field("out_empty", 32'(want.empty), 32'(got.empty));
				check_field("out_last", 32'(want.last), 32'(got.last));
				check_field("end_offset", want.end_off, got.end_off);
				check_field("kept_count", want.count, got.count);
				check_field("too_long", 32'(want.too_long), 32'(got.too_long));
			end
		end
	end

	// receiver: long hold-off when asked, otherwise random stalls
	initial begin : ready_drive
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	initial begin : watchdog
		int cycle_count;
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("adjacent_string_dedup_top_tb: errors");
		$finish;
	end

	// offer one item, with random idle cycles ahead of it, until it is taken
	task automatic send_item(input logic [7:0] d, input logic e, input logic l);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= d;
		s_tuser  <= e;
		s_tlast  <= l;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		dedup_take_item(d, e, l);
		items_sent++;
	endtask

	// bytes of one string, closed by last_byte or by an empty marker
	task automatic send_text(input text_t txt, input logic by_marker);
		int k;
		for (k = 0; k < txt.size(); k++)
			send_item(txt[k], 1'b0, !by_marker && k == txt.size() - 1);
		if (by_marker || txt.size() == 0)
			send_item(8'($urandom), 1'b1, 1'($urandom));
	endtask

	function automatic text_t fresh_text(input int len);
		text_t t;
		int    k;
		for (k = 0; k < len; k++)
			t.push_back(8'($urandom));
		return t;
	endfunction

	// sender goes quiet until every predicted item has come out
	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (kept_replay_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_directed();
		text_t t;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		// empty first string matches the zero stored length, so it is dropped
		send_item(8'hA5, 1'b1, 1'b1);
		send_item(8'h00, 1'b0, 1'b1);
		send_item(8'h00, 1'b0, 1'b1);
		send_item(8'hFF, 1'b0, 1'b1);
		// empty marker ignores last_byte; a second empty string is a repeat
		send_item(8'h5A, 1'b1, 1'b0);
		send_item(8'hC3, 1'b1, 1'b1);
		t = {8'h41, 8'h42};
		send_text(t, 1'b0);
		send_text(t, 1'b0);
		// same length, last byte differs
		t = {8'h41, 8'h43};
		send_text(t, 1'b0);
		// shorter prefix, then longer
		t = {8'h41};
		send_text(t, 1'b0);
		t = {8'h41, 8'h43, 8'h44};
		send_text(t, 1'b0);
		// equal string closed by an empty marker with pending bytes
		send_text(t, 1'b1);
		t = {8'h58, 8'h59};
		send_text(t, 1'b1);
		recent_text = t;
		drain_results();
	endtask

	task automatic test_overlong();
		text_t t;
		text_t head;
		t = fresh_text(MAX_LEN_DEF + 2);
		send_text(t, 1'b0);
		// truncated bytes equal the full-length string, so this one is dropped
		head = t[0:MAX_LEN_DEF - 1];
		send_text(head, 1'b1);
		recent_text = head;
		drain_results();
	endtask

	// receiver blocked for a long stretch while the sender keeps offering
	task automatic test_backpressure();
		int k;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_left = HOLD_CYCLES;
		for (k = 0; k < 3; k++)
			send_text(fresh_text(8), 1'b0);
		drain_results();
	endtask

	// mostly well-formed strings, many of them repeats or near-repeats
	task automatic test_random(input int n_items, input int idle_pct, input int stall_pct);
		text_t t;
		int    start;
		int    mode;
		int    pos;
		int    k;
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		start = items_sent;
		while (items_sent - start < n_items) begin
			mode = $urandom_range(99);
			t = recent_text;
			if (mode < 25) begin
				// exact repeat
			end else if (mode < 45) begin
				if (t.size() == 0) begin
					t.push_back(8'($urandom));
				end else begin
					pos = $urandom_range(t.size() - 1);
					t[pos] = t[pos] ^ (8'd1 << $urandom_range(7));
				end
			end else if (mode < 55) begin
				if (t.size() != 0 && $urandom_range(1))
					void'(t.pop_back());
				else
					t.push_back(8'($urandom));
			end else if (mode < 62) begin
				t.delete();
			end else if (mode < 65) begin
				t = fresh_text($urandom_range(MAX_LEN_DEF - 4, MAX_LEN_DEF + 6));
			end else if (mode < 93) begin
				t = fresh_text(($urandom_range(9) == 0) ? $urandom_range(9, 30)
					: $urandom_range(1, 8));
			end else begin
				// noise: loose items with random flags
				for (k = 0; k < $urandom_range(1, 4); k++)
					send_item(8'($urandom), 1'($urandom), 1'($urandom));
				t.delete();
				recent_text = t;
				continue;
			end
			send_text(t, $urandom_range(3) == 0);
			recent_text = t;
		end
		drain_results();
	endtask

	initial begin : run
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_overlong();
		test_backpressure();
		test_random(PHASE_ITEMS, 0, 0);
		test_random(PHASE_ITEMS, 65, 0);
		test_random(PHASE_ITEMS, 0, 65);
		test_random(PHASE_ITEMS, 7, 7);
		repeat (DRAIN_PAD) @(posedge clk);
		if (error_count == 0 && kept_replay_q.size() == 0)
			$display("adjacent_string_dedup_top_tb: clean");
		else
			$display("adjacent_string_dedup_top_tb: errors");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+src
src/asd_pkg.sv
src/asd_datapath.sv
src/asd_ctrl.sv
src/adjacent_string_dedup_top.sv
bench/adjacent_string_dedup_top_tb.sv
